// File: rtl/tpud_pkg.sv
`timescale 1ns / 1ps

package tpud_pkg;

    // Code point width and the mark shown in place of a space
    localparam int unsigned CP_W       = 21;
    localparam logic [CP_W-1:0] SPACE_MARK = 21'h002581;
    localparam logic [CP_W-1:0] SPACE_CP   = 21'h000020;

    // Queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    // Normalized byte codes
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    // Up to three code points caused by one input transaction
    typedef struct packed {
        logic [2:0][CP_W-1:0] cp;
        logic [1:0]           last_idx;
        logic                 text_end;
    } bundle_t;

endpackage

// File: rtl/text_prenormalize_utf8_decode_top.sv
`timescale 1ns / 1ps
// Channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | text_byte, byte_valid, text_end
// output   | out_valid | out_stall | code_point, run_last, text_last
//
// One input transaction per cycle while in_stall is low; the front decodes it in the cycle it is taken.
// Results leave one per cycle while out_stall is low, from a four-entry queue, so an item that
// yields two or three code points holds the output until all of them have left.
// Results are registered in the queue before they reach the output.
// in_stall is high only while the queue is full; reset clears text state and queue.

module text_prenormalize_utf8_decode_top
    import tpud_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      text_byte,
    input  logic            byte_valid,
    input  logic            text_end,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [CP_W-1:0] code_point,
    output logic            run_last,
    output logic            text_last
);

    logic    accept;
    logic    push;
    logic    pop;
    logic    empty;
    logic    full;
    bundle_t bundle;
    bundle_t head;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    tpud_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_byte  (text_byte),
        .byte_valid (byte_valid),
        .text_end   (text_end),
        .push       (push),
        .bundle     (bundle)
    );

    tpud_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (bundle),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    tpud_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .run_last   (run_last),
        .text_last  (text_last)
    );

    // Checks
    a_text_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_last |-> run_last)
        else $error("text_last without run_last");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("result run broken");

    a_stall_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with nothing queued");

    a_no_raw_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> code_point != SPACE_CP)
        else $error("raw space leaked to output");

endmodule

// File: rtl/tpud_front.sv
`timescale 1ns / 1ps

module tpud_front
    import tpud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] text_byte,
    input  logic       byte_valid,
    input  logic       text_end,
    output logic       push,
    output bundle_t    bundle
);

    typedef struct packed {
        logic [1:0]      rem;
        logic [CP_W-1:0] part;
        logic            emit;
        logic [CP_W-1:0] cp;
    } dec_t;

    // One byte through the UTF-8 decoder
    function automatic dec_t decode_step(input logic [1:0] rem, input logic [CP_W-1:0] part,
                                         input logic [7:0] b);
        dec_t            d;
        logic [1:0]      rem_n;
        logic [CP_W-1:0] pay;
        d     = '0;
        rem_n = 2'd0;
        pay   = {15'b0, b[5:0]};
        d.rem  = rem;
        d.part = part;
        if (rem == 2'd0)
        begin
            if (b[7] == 1'b0)
            begin
                d.emit = 1'b1;
                d.cp   = {13'b0, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                d.part = {10'b0, b[4:0], 6'b0};
                d.rem  = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                d.part = {5'b0, b[3:0], 12'b0};
                d.rem  = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                d.part = {b[2:0], 18'b0};
                d.rem  = 2'd3;
            end
            else
            begin
                // invalid lead gives zero and consumes only itself
                d.emit = 1'b1;
                d.cp   = '0;
            end
        end
        else
        begin
            rem_n = rem - 2'd1;
            case (rem_n)
                2'd0:    d.part = part | pay;
                2'd1:    d.part = part | (pay << 6);
                2'd2:    d.part = part | (pay << 12);
                default: d.part = part | (pay << 18);
            endcase
            d.rem = rem_n;
            if (rem_n == 2'd0)
            begin
                d.emit = 1'b1;
                d.cp   = d.part;
                d.part = '0;
            end
        end
        return d;
    endfunction

    function automatic logic [CP_W-1:0] map_space(input logic [CP_W-1:0] cp);
        return (cp == SPACE_CP) ? SPACE_MARK : cp;
    endfunction

    logic            seen_reg, seen_next;
    logic            held_reg, held_next;
    logic [1:0]      rem_reg, rem_next;
    logic [CP_W-1:0] part_reg, part_next;

    logic [7:0]           nb;
    logic                 is_space;
    dec_t                 d_sp;
    dec_t                 d_by;
    logic [1:0]           rem_a;
    logic [CP_W-1:0]      part_a;
    logic [1:0]           n;
    logic                 any;
    logic [2:0][CP_W-1:0] slots;

    // Normalize, decode, flush at end and pack the results
    always_comb
    begin
        nb = (text_byte == BYTE_TAB || text_byte == BYTE_LF || text_byte == BYTE_CR)
             ? BYTE_SPACE : text_byte;
        is_space  = (nb == BYTE_SPACE);
        seen_next = seen_reg;
        held_next = held_reg;
        rem_next  = rem_reg;
        part_next = part_reg;
        n         = 2'd0;
        any       = 1'b0;
        slots     = '0;
        d_sp      = decode_step(rem_reg, part_reg, BYTE_SPACE);
        rem_a     = rem_reg;
        part_a    = part_reg;

        if (byte_valid)
        begin
            if (is_space)
            begin
                if (seen_reg)
                    held_next = 1'b1;
            end
            else
            begin
                if (!seen_reg || held_reg)
                begin
                    rem_a  = d_sp.rem;
                    part_a = d_sp.part;
                    if (d_sp.emit)
                    begin
                        slots[n] = map_space(d_sp.cp);
                        n        = n + 2'd1;
                        any      = 1'b1;
                    end
                end
                seen_next = 1'b1;
                held_next = 1'b0;
            end
        end

        d_by = decode_step(rem_a, part_a, nb);
        if (byte_valid && !is_space)
        begin
            rem_next  = d_by.rem;
            part_next = d_by.part;
            if (d_by.emit)
            begin
                slots[n] = map_space(d_by.cp);
                n        = n + 2'd1;
                any      = 1'b1;
            end
        end
        else
        begin
            rem_next  = rem_a;
            part_next = part_a;
        end

        if (text_end)
        begin
            if (!seen_next)
            begin
                slots[n] = SPACE_MARK;
                n        = n + 2'd1;
                any      = 1'b1;
            end
            else if (rem_next != 2'd0)
            begin
                slots[n] = map_space(part_next);
                n        = n + 2'd1;
                any      = 1'b1;
            end
            seen_next = 1'b0;
            held_next = 1'b0;
            rem_next  = 2'd0;
            part_next = '0;
        end

        push            = accept && any;
        bundle.cp       = slots;
        bundle.last_idx = n - 2'd1;
        bundle.text_end = text_end;
    end

    // Text state, updated on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            held_reg <= 1'b0;
            rem_reg  <= 2'd0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
            held_reg <= held_next;
            rem_reg  <= rem_next;
            part_reg <= part_next;
        end
    end

endmodule

// File: rtl/tpud_queue.sv
`timescale 1ns / 1ps

module tpud_queue
    import tpud_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output logic    empty,
    output logic    full
);

    bundle_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/tpud_back.sv
`timescale 1ns / 1ps

module tpud_back
    import tpud_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  bundle_t         head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [CP_W-1:0] code_point,
    output logic            run_last,
    output logic            text_last
);

    logic [1:0] idx_reg, idx_next;
    logic       take;

    // Walk through the head entry one code point per transaction
    always_comb
    begin
        out_valid  = !empty;
        code_point = head.cp[idx_reg];
        run_last   = (idx_reg == head.last_idx);
        text_last  = run_last && head.text_end;
        take       = out_valid && !out_stall;
        pop        = take && run_last;
        idx_next   = idx_reg;
        if (take)
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

// File: tb/text_prenormalize_utf8_decode_top_tb.sv
`timescale 1ns / 1ps

module text_prenormalize_utf8_decode_top_tb;
    import tpud_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 100;
    localparam int TAIL_ITEMS     = 30;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            run_last;
        logic            text_last;
    } cp_result_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [7:0]      text_byte;
    logic            byte_valid;
    logic            text_end;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [CP_W-1:0] code_point;
    logic            run_last;
    logic            text_last;

    // Predictor state for the text currently being normalised
    logic            saw_text;
    logic            space_pending;
    logic [1:0]      dec_remaining;
    logic [CP_W-1:0] dec_partial;

    cp_result_t      pending_cps[$];
    logic [CP_W-1:0] item_cps[$];

    int errors      = 0;
    int items_sent  = 0;
    int idle_cycles = 0;

    // Idling controls; hold requests are served by the receiver process
    bit tx_idle_en  = 1'b0;
    bit rx_idle_en  = 1'b0;
    int hold_req    = 0;
    int hold_ack    = 0;
    int hold_left   = 0;
    int rx_gap_left = 0;

    text_prenormalize_utf8_decode_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .byte_valid (byte_valid),
        .text_end   (text_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .run_last   (run_last),
        .text_last  (text_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_text_state();
        saw_text      = 1'b0;
        space_pending = 1'b0;
        dec_remaining = 2'd0;
        dec_partial   = '0;
    endfunction

    // at most three code points per transaction; a space shows as the mark
    function automatic void emit_cp(input logic [CP_W-1:0] cp);
        if (item_cps.size() < 3)
            item_cps = {item_cps, ((cp == SPACE_CP) ? SPACE_MARK : cp)};
    endfunction

    function automatic void decode_norm_byte(input logic [7:0] b);
        if (dec_remaining == 2'd0)
        begin
            if (b[7] == 1'b0)
                emit_cp({13'b0, b});
            else if (b[7:5] == 3'b110)
            begin
                dec_partial   = {10'b0, b[4:0], 6'b0};
                dec_remaining = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                dec_partial   = {5'b0, b[3:0], 12'b0};
                dec_remaining = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                dec_partial   = {b[2:0], 18'b0};
                dec_remaining = 2'd3;
            end
            else
                emit_cp('0);    // bad lead byte
        end
        else
        begin
            // any byte counts as a continuation, no check of its top bits
            dec_remaining = dec_remaining - 2'd1;
            dec_partial   = dec_partial | ({15'b0, b[5:0]} << (6 * dec_remaining));
            if (dec_remaining == 2'd0)
            begin
                emit_cp(dec_partial);
                dec_partial = '0;
            end
        end
    endfunction

    function automatic void predict_code_points(input logic [7:0] b, input logic bv,
                                                input logic te);
        logic [7:0] nb;
        cp_result_t r;
        int         last_i;
        item_cps.delete();
        if (bv)
        begin
            nb = (b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR) ? BYTE_SPACE : b;
            if (nb == BYTE_SPACE)
            begin
                if (saw_text)
                    space_pending = 1'b1;
            end
            else
            begin
                // leading mark, or one space standing for a collapsed run
                if (!saw_text || space_pending)
                    decode_norm_byte(BYTE_SPACE);
                decode_norm_byte(nb);
                saw_text      = 1'b1;
                space_pending = 1'b0;
            end
        end
        if (te)
        begin
            if (!saw_text)
                emit_cp(SPACE_CP);
            else if (dec_remaining != 2'd0)
                emit_cp(dec_partial);   // truncated sequence, missing bits zero
            clear_text_state();
        end
        last_i = item_cps.size() - 1;
        for (int i = 0; i <= last_i; i++)
        begin
            r.cp        = item_cps[i];
            r.run_last  = (i == last_i);
            r.text_last = te && (i == last_i);
            pending_cps = {pending_cps, r};
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: records accepted input, checks accepted output, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        cp_result_t want;
        bit         busy;
        if (rst_n)
        begin
            busy = 1'b0;
            if (in_valid && !in_stall)
            begin
                predict_code_points(text_byte, byte_valid, text_end);
                busy = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                if (pending_cps.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual cp %h", $time,
                             code_point);
                    errors++;
                end
                else
                begin
                    want = pending_cps.pop_front();
                    if (code_point !== want.cp)
                    begin
                        $display("%0t: code_point mismatch, expected %h, actual %h", $time,
                                 want.cp, code_point);
                        errors++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $display("%0t: run_last mismatch, expected %b, actual %b", $time,
                                 want.run_last, run_last);
                        errors++;
                    end
                    if (text_last !== want.text_last)
                    begin
                        $display("%0t: text_last mismatch, expected %b, actual %b", $time,
                                 want.text_last, text_last);
                        errors++;
                    end
                end
            end
            if (busy)
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: watchdog, no transaction for %0d cycles", $time,
                             idle_cycles);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: long hold-off on request, else random stall bursts
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_ack != hold_req)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_gap_left > 0)
            begin
                rx_gap_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                rx_gap_left = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_text_item(input logic [7:0] b, input logic bv, input logic te);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        byte_valid <= bv;
        text_end   <= te;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_whitespace();
        case ($urandom_range(0, 3))
            0:       return BYTE_TAB;
            1:       return BYTE_LF;
            2:       return BYTE_CR;
            default: return BYTE_SPACE;
        endcase
    endfunction

    // One text: mostly printable ASCII and well-formed sequences, some noise
    task automatic send_random_text(input int max_len);
        int         len;
        int         kind;
        int         nbytes;
        bit         sep_end;
        bit         fin;
        logic [7:0] seq[4];
        len     = $urandom_range(0, max_len);
        sep_end = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            kind = $urandom_range(0, 19);
            fin  = (i == len - 1) && !sep_end;
            if (kind < 8)
                send_text_item(8'($urandom_range(8'h21, 8'h7E)), 1'b1, fin);
            else if (kind < 11)
                send_text_item(pick_whitespace(), 1'b1, fin);
            else if (kind < 15)
            begin
                nbytes = $urandom_range(2, 4);
                for (int k = 1; k < 4; k++)
                    seq[k] = {2'b10, 6'($urandom_range(0, 63))};
                case (nbytes)
                    2:       seq[0] = {3'b110, 5'($urandom_range(0, 31))};
                    3:       seq[0] = {4'b1110, 4'($urandom_range(0, 15))};
                    default: seq[0] = {5'b11110, 3'($urandom_range(0, 7))};
                endcase
                for (int k = 0; k < nbytes; k++)
                    send_text_item(seq[k], 1'b1, fin && (k == nbytes - 1));
            end
            else if (kind < 17)
                send_text_item(8'($urandom_range(0, 255)), 1'b1, fin);
            else if (kind < 18)
                send_text_item(8'($urandom_range(0, 255)), 1'b0, fin);
            else
                send_text_item({2'b10, 6'($urandom_range(0, 63))}, 1'b1, fin);
        end
        // end as its own transaction: no data, or trailing whitespace
        if (sep_end)
        begin
            if ($urandom_range(0, 1) == 0)
                send_text_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            else
                send_text_item(pick_whitespace(), 1'b1, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        // empty text, then whitespace only
        send_text_item(8'h00, 1'b0, 1'b1);
        send_text_item(BYTE_TAB, 1'b1, 1'b0);
        send_text_item(BYTE_LF, 1'b1, 1'b0);
        send_text_item(BYTE_CR, 1'b1, 1'b0);
        send_text_item(BYTE_SPACE, 1'b1, 1'b1);
        // ASCII extremes, collapsed run, bad lead bytes
        send_text_item(8'h00, 1'b1, 1'b0);
        send_text_item(8'h7F, 1'b1, 1'b0);
        send_text_item(BYTE_SPACE, 1'b1, 1'b0);
        send_text_item(BYTE_TAB, 1'b1, 1'b0);
        send_text_item(8'hFF, 1'b1, 1'b0);
        send_text_item(8'h80, 1'b1, 1'b0);
        // two-byte and largest four-byte sequences
        send_text_item(8'hC3, 1'b1, 1'b0);
        send_text_item(8'hA9, 1'b1, 1'b0);
        send_text_item(8'hF7, 1'b1, 1'b0);
        send_text_item(8'hBF, 1'b1, 1'b0);
        send_text_item(8'hBF, 1'b1, 1'b0);
        send_text_item(8'hBF, 1'b1, 1'b0);
        // transaction without data
        send_text_item(8'hA5, 1'b0, 1'b0);
        // held space closes an open sequence, new lead is flushed at the end
        send_text_item(8'hE2, 1'b1, 1'b0);
        send_text_item(8'h82, 1'b1, 1'b0);
        send_text_item(BYTE_LF, 1'b1, 1'b0);
        send_text_item(8'hE2, 1'b1, 1'b1);
        // trailing whitespace, end gives no code point
        send_text_item(8'h41, 1'b1, 1'b0);
        send_text_item(BYTE_SPACE, 1'b1, 1'b0);
        send_text_item(8'h5A, 1'b0, 1'b1);
        // truncated sequence ended by a no-data transaction
        send_text_item(8'hF0, 1'b1, 1'b0);
        send_text_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random_texts();
        int target;
        target     = items_sent + RANDOM_ITEMS;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (items_sent < target)
            send_random_text(12);
    endtask

    // receiver holds off while words keep coming, so the queue fills
    task automatic test_output_hold_off();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req++;
        for (int i = 0; i < 8; i++)
        begin
            send_text_item(8'($urandom_range(8'h61, 8'h7A)), 1'b1, 1'b0);
            send_text_item(BYTE_SPACE, 1'b1, 1'b0);
        end
        send_text_item(8'($urandom_range(8'h61, 8'h7A)), 1'b1, 1'b1);
    endtask

    task automatic test_back_to_back();
        int target;
        target     = items_sent + TAIL_ITEMS;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (items_sent < target)
            send_random_text(8);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        text_byte  = 8'h00;
        byte_valid = 1'b0;
        text_end   = 1'b0;
        clear_text_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_texts();
        test_output_hold_off();
        test_back_to_back();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_cps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
rtl/tpud_pkg.sv
rtl/tpud_front.sv
rtl/tpud_queue.sv
rtl/tpud_back.sv
rtl/text_prenormalize_utf8_decode_top.sv
tb/text_prenormalize_utf8_decode_top_tb.sv
